[hw/rtl/btid_pkg.sv]
// Package for the batched timestamp ID generator.
// It holds the field widths, the reset values and the pool and global ID record types.
// It has no dependencies and is used by btid_alloc and the top level.
package btid_pkg;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned SecW     = 34;
  localparam int unsigned NanoW    = 30;
  localparam int unsigned CntW     = 48;
  localparam int unsigned BatchW   = 16;
  localparam int unsigned InDataW  = SecW + NanoW;
  localparam int unsigned OutDataW = SecW + NanoW + CntW;

  localparam int unsigned NumRequestersDef = 4;
  localparam logic [BatchW-1:0] BatchReset = BatchW'(1000);

  typedef struct packed {
    logic [BatchW-1:0] remaining;
    logic [CntW-1:0]   count;
    logic [NanoW-1:0]  nanos;
    logic [SecW-1:0]   seconds;
  } pool_entry_t;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [NanoW-1:0] nanos;
    logic [SecW-1:0]  seconds;
  } global_id_t;

  localparam int unsigned PoolEntryW = $bits(pool_entry_t);

endpackage

[hw/rtl/btid_ram.sv]
// Generic single write port RAM with a registered read port.
// Holds the per-requester pool records; depends on nothing else.
module btid_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/btid_alloc.sv]
// Allocation logic: decides between the local pool and a new batch from the global ID.
// Purely combinational; depends on btid_pkg for widths and record types.
module btid_alloc (
  input  logic [btid_pkg::BatchW-1:0] batch_i,
  input  logic [btid_pkg::SecW-1:0]   now_seconds_i,
  input  logic [btid_pkg::NanoW-1:0]  now_nanos_i,
  input  logic                        pool_valid_i,
  input  btid_pkg::pool_entry_t       pool_i,
  input  btid_pkg::global_id_t        glob_i,
  output btid_pkg::pool_entry_t       pool_o,
  output btid_pkg::global_id_t        glob_o,
  output logic                        fresh_o
);
  import btid_pkg::*;

  logic pool_hit;
  logic first;
  logic after;
  logic [CntW-1:0] glob_sum;

  assign pool_hit = pool_valid_i && (pool_i.remaining != '0);
  assign first    = (glob_i.seconds == '0) && (glob_i.nanos == '0) && (glob_i.count == '0);
  assign after    = (now_seconds_i > glob_i.seconds) ||
                    ((now_seconds_i == glob_i.seconds) && (now_nanos_i > glob_i.nanos));
  assign glob_sum = glob_i.count + CntW'(batch_i);

  always_comb begin
    pool_o  = pool_i;
    glob_o  = glob_i;
    fresh_o = 1'b0;
    if (pool_hit) begin
      pool_o.remaining = pool_i.remaining - BatchW'(1);
      pool_o.count     = pool_i.count + CntW'(1);
    end else begin
      fresh_o = 1'b1;
      if (first || after) begin
        pool_o.seconds = now_seconds_i;
        pool_o.nanos   = now_nanos_i;
        pool_o.count   = '0;
        glob_o.seconds = now_seconds_i;
        glob_o.nanos   = now_nanos_i;
        glob_o.count   = CntW'(batch_i);
      end else begin
        glob_o.count   = glob_sum;
        pool_o.seconds = glob_i.seconds;
        pool_o.nanos   = glob_i.nanos;
        pool_o.count   = glob_sum;
      end
      pool_o.remaining = (batch_i != '0) ? (batch_i - BatchW'(1)) : '0;
    end
  end

endmodule

[hw/rtl/batched_timestamp_id_generator.sv]
// Top level of the batched timestamp ID generator: handshakes, pool RAM, global ID.
// Depends on btid_pkg, btid_ram and btid_alloc.
//
//   Channel  | Direction | Word contents (lowest bit first)
//   s_axis   | in        | tdata: now_seconds, now_nanos; tuser: requester
//   m_axis   | out       | tdata: id_seconds, id_nanos, id_count; tuser: new_batch
//   cfg      | in        | cfg_wdata_i: batch_size, written when cfg_we_i is high
//
// A word waits in the input register, where the pool record is read from RAM,
// and is resolved into the result register once that register is free to take it.
// One word is taken every cycle while m_axis does not stall; the pool RAM read and the single allocation step set this.
// The result register stalls on m_axis_tready, and the input register stalls behind it.
// Reset clears the global ID, the pool valid bits and the handshake state at once.
module batched_timestamp_id_generator #(
  parameter int unsigned NUM_REQUESTERS = btid_pkg::NumRequestersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [btid_pkg::InDataW-1:0]    s_axis_tdata,  // now_seconds, now_nanos
  input  logic [btid_pkg::ReqW-1:0]       s_axis_tuser,  // requester
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [btid_pkg::OutDataW-1:0]   m_axis_tdata,  // id_seconds, id_nanos, id_count
  output logic                            m_axis_tuser,  // new_batch
  input  logic                            cfg_we_i,
  input  logic [btid_pkg::BatchW-1:0]     cfg_wdata_i    // batch_size
);
  import btid_pkg::*;

  localparam int unsigned IdxW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;

  function automatic logic [IdxW-1:0] req_to_idx(input logic [ReqW-1:0] req);
    int unsigned v;
    v = req;
    for (int unsigned k = 0; k < (1 << ReqW) - 1; k++) begin
      if (v >= NUM_REQUESTERS) begin
        v = v - NUM_REQUESTERS;
      end
    end
    return IdxW'(v);
  endfunction

  logic [BatchW-1:0]         batch_q;
  global_id_t                glob_q, glob_d;
  logic [NUM_REQUESTERS-1:0] valid_q;

  logic                      in_valid_q;
  logic [IdxW-1:0]           idx_q;
  logic [SecW-1:0]           now_s_q;
  logic [NanoW-1:0]          now_n_q;
  logic                      fwd_hit_q;
  pool_entry_t               fwd_q;

  logic                      out_valid_q;
  logic [OutDataW-1:0]       out_data_q;
  logic                      out_fresh_q;

  logic                      proc;
  logic                      accept;
  logic [IdxW-1:0]           s_idx;
  logic [PoolEntryW-1:0]     ram_rdata;
  pool_entry_t               pool_rd;
  pool_entry_t               pool_d;
  logic                      fresh;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_idx         = req_to_idx(s_axis_tuser);

  btid_ram #(
    .Width(PoolEntryW),
    .Depth(NUM_REQUESTERS)
  ) u_pool_ram (
    .clk_i  (clk_i),
    .we_i   (proc),
    .waddr_i(idx_q),
    .wdata_i(pool_d),
    .re_i   (accept),
    .raddr_i(s_idx),
    .rdata_o(ram_rdata)
  );

  assign pool_rd = fwd_hit_q ? fwd_q : pool_entry_t'(ram_rdata);

  btid_alloc u_alloc (
    .batch_i      (batch_q),
    .now_seconds_i(now_s_q),
    .now_nanos_i  (now_n_q),
    .pool_valid_i (valid_q[idx_q]),
    .pool_i       (pool_rd),
    .glob_i       (glob_q),
    .pool_o       (pool_d),
    .glob_o       (glob_d),
    .fresh_o      (fresh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q     <= BatchReset;
      glob_q      <= '0;
      valid_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        batch_q <= cfg_wdata_i;
      end
      if (proc) begin
        glob_q         <= glob_d;
        valid_q[idx_q] <= 1'b1;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
        fwd_hit_q  <= proc && (idx_q == s_idx);
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= s_idx;
      now_s_q <= s_axis_tdata[SecW-1:0];
      now_n_q <= s_axis_tdata[InDataW-1:SecW];
      fwd_q   <= pool_d;
    end
    if (proc) begin
      out_data_q  <= {pool_d.count, pool_d.nanos, pool_d.seconds};
      out_fresh_q <= fresh;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fresh_q;

endmodule
